@@ sv/per_core_memory_watermark_assert.svh @@
// assertion macros shared by the watermark tracker
`ifndef PER_CORE_MEMORY_WATERMARK_ASSERT_SVH
`define PER_CORE_MEMORY_WATERMARK_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PCMW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PCMW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pcmw_pkg.sv @@
// types, constants and helper functions of the watermark tracker
`default_nettype none

package pcmw_pkg;

  localparam int AccBits   = 48;
  localparam int OutBits   = 48;
  localparam int OpBits    = 3;
  localparam int SeqBits   = 32;
  localparam int SizeBits  = 31;
  localparam int CoreBits  = 16;
  localparam int StatBits  = 2;
  localparam int DivBits   = 32;
  localparam int DivCntW   = $clog2(DivBits);

  localparam logic [CoreBits-1:0] DefaultCores = 16'd64;

  localparam logic [OpBits-1:0] OP_CB_ALLOC    = 3'd0;
  localparam logic [OpBits-1:0] OP_CB_FREE_ALL = 3'd1;
  localparam logic [OpBits-1:0] OP_BUF_ALLOC   = 3'd2;
  localparam logic [OpBits-1:0] OP_BUF_FREE    = 3'd3;

  localparam logic [StatBits-1:0] FAULT_NONE  = 2'd0;
  localparam logic [StatBits-1:0] FAULT_ORDER = 2'd1;
  localparam logic [StatBits-1:0] FAULT_PAGE  = 2'd2;

  typedef logic [AccBits-1:0] acc_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic [AccBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccBits] ? '1 : s[AccBits-1:0];
  endfunction

  function automatic acc_t clamp_sub(acc_t a, acc_t b);
    return (b >= a) ? '0 : a - b;
  endfunction

  function automatic acc_t max_acc(acc_t a, acc_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [OutBits-1:0] to_out(acc_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[OutBits-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/pcmw_channels.sv @@
// valid/ready channel interfaces for events and results
`default_nettype none

interface pcmw_in_if
  import pcmw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OpBits-1:0]   opcode;
  logic [SeqBits-1:0]  sequence_number;
  logic                in_dram;
  logic                globally_allocated;
  logic [SizeBits-1:0] byte_size;
  logic [SizeBits-1:0] bytes_per_page;
  logic [CoreBits-1:0] core_count;

  modport source (
    output valid, opcode, sequence_number, in_dram, globally_allocated,
           byte_size, bytes_per_page, core_count,
    input  ready
  );

  modport sink (
    input  valid, opcode, sequence_number, in_dram, globally_allocated,
           byte_size, bytes_per_page, core_count,
    output ready
  );
endinterface

interface pcmw_out_if
  import pcmw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OutBits-1:0]  peak_circular;
  logic [OutBits-1:0]  peak_l1_buffers;
  logic [OutBits-1:0]  peak_combined;
  logic [StatBits-1:0] status;

  modport source (
    output valid, peak_circular, peak_l1_buffers, peak_combined, status,
    input  ready
  );

  modport sink (
    input  valid, peak_circular, peak_l1_buffers, peak_combined, status,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/per_core_memory_watermark.sv @@
// per-core memory usage and high-water tracker for allocation events
//
// Events enter on in_ch (valid/ready) in execution order; every accepted item
// yields exactly one result on out_ch carrying the three high-water marks and
// the latched fault code. cfg_we/cfg_wdata load the default core count.
// Circular-buffer and other events pass through the prepare and apply states
// before out_ch.valid rises. Non-DRAM buffer events with a nonzero page size,
// in order and with no latched fault, also take two passes through the
// bit-serial divider (pages, then pages per core) and the shift-add multiplier,
// which stops once no multiplier bits remain, before the share is captured.
// One item is in work at a time; the next is taken only once the last is applied.
// A new item is taken while the previous result still waits on out_ch; the
// finished result of the second item is held until the output register frees.
// A stalled receiver therefore stalls the input after at most one item.
// Reset clears usage, marks, the sequence count and the fault, and sets the
// default core count to 64; in_ch.ready stays low while reset is held.
`default_nettype none

module per_core_memory_watermark
  import pcmw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  pcmw_in_if.sink                  in_ch,
  pcmw_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CoreBits-1:0] cfg_wdata
);

  `include "per_core_memory_watermark_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_PAGES,
    S_DIV_CORES,
    S_MUL,
    S_APPLY
  } state_t;

  state_t state_r;

  logic [OpBits-1:0]   op_r;
  logic [SeqBits-1:0]  seq_r;
  logic                dram_r;
  logic                glob_r;
  logic [SizeBits-1:0] size_r;
  logic [SizeBits-1:0] page_r;
  logic [CoreBits-1:0] cores_r;
  logic [DivBits-1:0]  share_r;

  logic [CoreBits-1:0] dflt_cores_r;
  logic [SeqBits-1:0]  exp_seq_r;
  logic [StatBits-1:0] fault_r;
  acc_t circ_now_r, l1_now_r, comb_now_r;
  acc_t circ_peak_r, l1_peak_r, comb_peak_r;

  logic                out_valid_r;
  logic [OutBits-1:0]  out_circ_r, out_l1_r, out_comb_r;
  logic [StatBits-1:0] out_stat_r;

  // serial units
  logic               div_start, mul_start;
  logic [DivBits-1:0] div_dividend, div_divisor, div_quo, mul_prod;
  unit_sts_t          div_sts, mul_sts;

  logic                is_buf;
  logic                buf_go;
  logic [CoreBits-1:0] cores_eff;

  logic [SeqBits-1:0]  exp_seq_nxt;
  logic [StatBits-1:0] fault_nxt;
  acc_t circ_now_nxt, l1_now_nxt, comb_now_nxt;
  acc_t circ_peak_nxt, l1_peak_nxt, comb_peak_nxt;

  logic in_fire, out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign is_buf = (op_r == OP_BUF_ALLOC) || (op_r == OP_BUF_FREE);
  assign buf_go = is_buf && (fault_r == FAULT_NONE) && (seq_r == exp_seq_r) &&
                  !dram_r && (page_r != '0);

  // zero core count falls back to the register, and a zero register to one core
  assign cores_eff = (cores_r != '0)      ? cores_r :
                     (dflt_cores_r != '0) ? dflt_cores_r : CoreBits'(1);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DivBits'(size_r) + DivBits'(page_r) - DivBits'(1);
    div_divisor  = DivBits'(page_r);
    if (state_r == S_PREP) begin
      div_start = buf_go;
    end else if (state_r == S_DIV_PAGES) begin
      div_start    = div_sts.done;
      div_dividend = div_quo + DivBits'(cores_eff) - DivBits'(1);
      div_divisor  = DivBits'(cores_eff);
    end
  end

  assign mul_start = (state_r == S_DIV_CORES) && div_sts.done;

  pcmw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .sts      (div_sts)
  );

  pcmw_mul u_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (mul_start),
    .multiplicand (page_r),
    .multiplier   (div_quo),
    .product      (mul_prod),
    .sts          (mul_sts)
  );

  // event update, used in the apply state
  always_comb begin
    acc_t addend;
    addend        = (op_r == OP_CB_ALLOC) ? AccBits'(size_r) : AccBits'(share_r);
    exp_seq_nxt   = exp_seq_r;
    fault_nxt     = fault_r;
    circ_now_nxt  = circ_now_r;
    l1_now_nxt    = l1_now_r;
    comb_now_nxt  = comb_now_r;
    if (fault_r == FAULT_NONE) begin
      if (seq_r != exp_seq_r) begin
        fault_nxt = FAULT_ORDER;
      end else begin
        exp_seq_nxt = exp_seq_r + 1'b1;
        case (op_r) inside
          OP_CB_ALLOC: begin
            if (!glob_r) begin
              circ_now_nxt = sat_add(circ_now_r, addend);
              comb_now_nxt = sat_add(comb_now_r, addend);
            end
          end
          OP_CB_FREE_ALL: begin
            comb_now_nxt = clamp_sub(comb_now_r, circ_now_r);
            circ_now_nxt = '0;
          end
          OP_BUF_ALLOC, OP_BUF_FREE: begin
            if (!dram_r) begin
              if (page_r == '0) begin
                fault_nxt = FAULT_PAGE;
              end else if (op_r == OP_BUF_ALLOC) begin
                l1_now_nxt   = sat_add(l1_now_r, addend);
                comb_now_nxt = sat_add(comb_now_r, addend);
              end else begin
                l1_now_nxt   = clamp_sub(l1_now_r, addend);
                comb_now_nxt = clamp_sub(comb_now_r, addend);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    circ_peak_nxt = max_acc(circ_peak_r, circ_now_nxt);
    l1_peak_nxt   = max_acc(l1_peak_r, l1_now_nxt);
    comb_peak_nxt = max_acc(comb_peak_r, comb_now_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dflt_cores_r <= DefaultCores;
      exp_seq_r    <= '0;
      fault_r      <= FAULT_NONE;
      circ_now_r   <= '0;
      l1_now_r     <= '0;
      comb_now_r   <= '0;
      circ_peak_r  <= '0;
      l1_peak_r    <= '0;
      comb_peak_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        dflt_cores_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_ch.opcode;
            seq_r   <= in_ch.sequence_number;
            dram_r  <= in_ch.in_dram;
            glob_r  <= in_ch.globally_allocated;
            size_r  <= in_ch.byte_size;
            page_r  <= in_ch.bytes_per_page;
            cores_r <= in_ch.core_count;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          state_r <= buf_go ? S_DIV_PAGES : S_APPLY;
        end
        S_DIV_PAGES: begin
          if (div_sts.done) begin
            state_r <= S_DIV_CORES;
          end
        end
        S_DIV_CORES: begin
          if (div_sts.done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            share_r <= mul_prod;
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            exp_seq_r   <= exp_seq_nxt;
            fault_r     <= fault_nxt;
            circ_now_r  <= circ_now_nxt;
            l1_now_r    <= l1_now_nxt;
            comb_now_r  <= comb_now_nxt;
            circ_peak_r <= circ_peak_nxt;
            l1_peak_r   <= l1_peak_nxt;
            comb_peak_r <= comb_peak_nxt;
            out_valid_r <= 1'b1;
            out_circ_r  <= to_out(circ_peak_nxt);
            out_l1_r    <= to_out(l1_peak_nxt);
            out_comb_r  <= to_out(comb_peak_nxt);
            out_stat_r  <= fault_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready            = rst_n && (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.peak_circular   = out_circ_r;
  assign out_ch.peak_l1_buffers = out_l1_r;
  assign out_ch.peak_combined   = out_comb_r;
  assign out_ch.status          = out_stat_r;

  `PCMW_ASSERT_NEXT(a_fault_sticky, fault_r != FAULT_NONE, fault_r == $past(fault_r),
                    "latched fault changed")
  `PCMW_ASSERT_NEXT(a_seq_only_apply, state_r != S_APPLY, $stable(exp_seq_r),
                    "sequence count moved outside apply")
  `PCMW_ASSERT_SAME(a_div_free, div_start, !div_sts.busy, "divider restarted while busy")
  `PCMW_ASSERT_SAME(a_circ_peak, 1'b1, circ_peak_r >= circ_now_r,
                    "circular usage above its mark")
  `PCMW_ASSERT_SAME(a_comb_peak, 1'b1, comb_peak_r >= comb_now_r,
                    "combined usage above its mark")

endmodule

`default_nettype wire

@@ sv/pcmw_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module pcmw_div
  import pcmw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DivBits-1:0] dividend,
  input  wire logic [DivBits-1:0] divisor,
  output logic      [DivBits-1:0] quotient,
  output unit_sts_t               sts
);

  logic               busy_r;
  logic               done_r;
  logic [DivCntW-1:0] cnt_r;
  logic [DivBits:0]   rem_r;
  logic [DivBits-1:0] quo_r;
  logic [DivBits-1:0] dvs_r;

  logic [DivBits:0]   trial;
  logic               fits;
  logic [DivBits:0]   rem_nxt;

  // dividend bits leave quo_r at the top while quotient bits enter at the bottom
  always_comb begin
    trial   = {rem_r[DivBits-1:0], quo_r[DivBits-1]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? trial - {1'b0, dvs_r} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DivBits-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivBits - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

@@ sv/pcmw_mul.sv @@
// shift-add multiplier, one multiplier bit per cycle, stops when no bits remain
`default_nettype none

module pcmw_mul
  import pcmw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SizeBits-1:0] multiplicand,
  input  wire logic [DivBits-1:0]  multiplier,
  output logic      [DivBits-1:0]  product,
  output unit_sts_t                sts
);

  logic               busy_r;
  logic               done_r;
  logic [DivBits-1:0] mcand_r;
  logic [DivBits-1:0] mplier_r;
  logic [DivBits-1:0] acc_r;

  // the product is known to fit, so arithmetic modulo the register width is exact
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        mcand_r  <= DivBits'(multiplicand);
        mplier_r <= multiplier;
        acc_r    <= '0;
      end else if (busy_r) begin
        if (mplier_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (mplier_r[0]) begin
            acc_r <= acc_r + mcand_r;
          end
          mcand_r  <= {mcand_r[DivBits-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[DivBits-1:1]};
        end
      end
    end
  end

  assign product  = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the per-core memory watermark tracker
`default_nettype none

module tb;
  import pcmw_pkg::*;

  localparam logic [OpBits-1:0] OP_OTHER = 3'd4;
  localparam logic [OpBits-1:0] OP_LAST = 3'd7;
  localparam logic [SizeBits-1:0] SIZE_FULL = '1;
  localparam acc_t ACC_FULL = '1;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int PRESSURE_ITEMS = 12;
  localparam int PRESSURE_HOLD = 300;
  // a short run of maximal circular allocations before the frees
  localparam int SAT_ITEMS = 8;
  localparam int NOISE_ITEMS = 24;
  localparam int SETTLE_CYCLES = 110;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [OpBits-1:0]   opcode;
    logic [SeqBits-1:0]  seq;
    logic                dram;
    logic                is_global;
    logic [SizeBits-1:0] size;
    logic [SizeBits-1:0] page;
    logic [CoreBits-1:0] cores;
  } event_t;

  typedef struct {
    logic [OutBits-1:0]  circ;
    logic [OutBits-1:0]  l1;
    logic [OutBits-1:0]  comb;
    logic [StatBits-1:0] status;
  } marks_t;

  class watermark_scoreboard;
    logic [CoreBits-1:0] default_cores;
    acc_t circ_now, l1_now, comb_now;
    acc_t circ_peak, l1_peak, comb_peak;
    logic [SeqBits-1:0] next_seq;
    logic [StatBits-1:0] fault;
    marks_t expected_marks[$];
    int unsigned failures;
    int unsigned checked;

    function new();
      default_cores = DefaultCores;
      circ_now = '0;
      l1_now = '0;
      comb_now = '0;
      circ_peak = '0;
      l1_peak = '0;
      comb_peak = '0;
      next_seq = '0;
      fault = FAULT_NONE;
      failures = 0;
      checked = 0;
    endfunction

    function acc_t add_sat(acc_t a, logic [63:0] b);
      logic [64:0] s;
      s = 65'(a) + 65'(b);
      return (s > 65'(ACC_FULL)) ? ACC_FULL : s[AccBits-1:0];
    endfunction

    function acc_t sub_floor(acc_t a, logic [63:0] b);
      return (b >= 64'(a)) ? '0 : a - acc_t'(b);
    endfunction

    // worst-case per-core bytes: pages rounded up, then spread over the cores rounded up
    function logic [63:0] core_share(logic [63:0] size, logic [63:0] page,
                                     logic [63:0] cores);
      logic [63:0] pages, per_core;
      pages = (size + page - 64'd1) / page;
      per_core = (pages + cores - 64'd1) / cores;
      return per_core * page;
    endfunction

    function void advance(event_t e);
      logic [63:0] cores, share;
      if (e.seq != next_seq) begin
        fault = FAULT_ORDER;
        return;
      end
      next_seq = next_seq + 1'b1;
      case (e.opcode) inside
        OP_CB_ALLOC: begin
          if (!e.is_global) begin
            circ_now = add_sat(circ_now, 64'(e.size));
            if (circ_now > circ_peak) circ_peak = circ_now;
            comb_now = add_sat(comb_now, 64'(e.size));
            if (comb_now > comb_peak) comb_peak = comb_now;
          end
        end
        OP_CB_FREE_ALL: begin
          comb_now = sub_floor(comb_now, 64'(circ_now));
          circ_now = '0;
        end
        OP_BUF_ALLOC, OP_BUF_FREE: begin
          if (!e.dram) begin
            if (e.page == '0) begin
              fault = FAULT_PAGE;
            end else begin
              cores = 64'(e.cores);
              if (cores == 0) cores = 64'(default_cores);
              if (cores == 0) cores = 64'd1;
              share = core_share(64'(e.size), 64'(e.page), cores);
              if (e.opcode == OP_BUF_ALLOC) begin
                l1_now = add_sat(l1_now, share);
                if (l1_now > l1_peak) l1_peak = l1_now;
                comb_now = add_sat(comb_now, share);
                if (comb_now > comb_peak) comb_peak = comb_now;
              end else begin
                l1_now = sub_floor(l1_now, share);
                comb_now = sub_floor(comb_now, share);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_event(event_t e);
      marks_t m;
      if (fault == FAULT_NONE) advance(e);
      m.circ = circ_peak;
      m.l1 = l1_peak;
      m.comb = comb_peak;
      m.status = fault;
      expected_marks = {expected_marks, m};
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      failures++;
      if (failures <= 10)
        $display("result %0d: %s expected %0h got %0h", checked, what, want, got);
    endfunction

    function void check_marks(marks_t got);
      marks_t want;
      if (expected_marks.size() == 0) begin
        report("result with nothing outstanding, peak_combined", 64'(0), 64'(got.comb));
        return;
      end
      want = expected_marks.pop_front();
      checked++;
      if (got.circ !== want.circ) report("peak_circular", 64'(want.circ), 64'(got.circ));
      if (got.l1 !== want.l1) report("peak_l1_buffers", 64'(want.l1), 64'(got.l1));
      if (got.comb !== want.comb) report("peak_combined", 64'(want.comb), 64'(got.comb));
      if (got.status !== want.status) report("status", 64'(want.status), 64'(got.status));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CoreBits-1:0] cfg_wdata;

  pcmw_in_if in_ch();
  pcmw_out_if out_ch();

  per_core_memory_watermark DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  watermark_scoreboard board = new();

  int send_idle_pct;
  int stall_pct;
  int hold_req;
  int unsigned cycles;
  int unsigned sent;
  int unsigned sat_sent;
  int unsigned cfg_writes;
  logic [SeqBits-1:0] issue_seq;
  event_t live_bufs[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("no completion after %0d cycles, %0d results outstanding", cycles,
             board.expected_marks.size());
    $display("per_core_memory_watermark test failed");
    $finish;
  end

  // result side: check every accepted item, then choose next ready
  initial begin
    int hold_left;
    marks_t got;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.circ = out_ch.peak_circular;
        got.l1 = out_ch.peak_l1_buffers;
        got.comb = out_ch.peak_combined;
        got.status = out_ch.status;
        board.check_marks(got);
      end
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic event_t ev(logic [OpBits-1:0] op, logic dram, logic is_global,
                                logic [SizeBits-1:0] size, logic [SizeBits-1:0] page,
                                logic [CoreBits-1:0] cores);
    event_t e;
    e.opcode = op;
    e.seq = '0;
    e.dram = dram;
    e.is_global = is_global;
    e.size = size;
    e.page = page;
    e.cores = cores;
    return e;
  endfunction

  function automatic logic [SizeBits-1:0] pick_size();
    case ($urandom_range(5))
      0: return SizeBits'($urandom_range(64));
      1: return SizeBits'($urandom_range(4096));
      2: return SizeBits'($urandom_range(1 << 20));
      3: return SizeBits'($urandom);
      4: return SIZE_FULL;
      default: return SizeBits'($urandom) >> $urandom_range(30);
    endcase
  endfunction

  // never zero
  function automatic logic [SizeBits-1:0] pick_page();
    case ($urandom_range(4))
      0: return SizeBits'(1) << $urandom_range(30);
      1: return SizeBits'($urandom_range(1, 4096));
      2: return SizeBits'($urandom_range(1, 32'h7fff_ffff));
      3: return SIZE_FULL;
      default: return SizeBits'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [CoreBits-1:0] pick_cores();
    case ($urandom_range(4))
      0: return '0;
      1: return CoreBits'($urandom_range(1, 8));
      2: return CoreBits'($urandom);
      3: return '1;
      default: return CoreBits'($urandom_range(1, 128));
    endcase
  endfunction

  function automatic event_t random_event();
    event_t e;
    int r;
    int k;
    r = $urandom_range(99);
    e = ev(OP_CB_ALLOC, 1'($urandom), ($urandom_range(5) == 0), pick_size(),
           SizeBits'($urandom), CoreBits'($urandom));
    if (r < 22) begin
      e.opcode = OP_CB_ALLOC;
    end else if (r < 30) begin
      e.opcode = OP_CB_FREE_ALL;
    end else if (r < 62) begin
      e.opcode = OP_BUF_ALLOC;
      e.is_global = 1'($urandom);
      e.dram = ($urandom_range(7) == 0);
      e.page = (e.dram && $urandom_range(1)) ? '0 : pick_page();
      e.cores = pick_cores();
      if (!e.dram) begin
        live_bufs = {live_bufs, e};
        if (live_bufs.size() > 32) void'(live_bufs.pop_front());
      end
    end else if (r < 92) begin
      // mostly release something still allocated
      if (live_bufs.size() != 0 && $urandom_range(9) < 6) begin
        k = $urandom_range(live_bufs.size() - 1);
        e = live_bufs[k];
        live_bufs.delete(k);
      end else begin
        e.dram = ($urandom_range(7) == 0);
        e.page = e.dram ? SizeBits'($urandom) : pick_page();
        e.cores = pick_cores();
      end
      e.opcode = OP_BUF_FREE;
    end else begin
      e.opcode = OpBits'($urandom_range(OP_OTHER, OP_LAST));
    end
    return e;
  endfunction

  task automatic send_event(input event_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= e.opcode;
    in_ch.sequence_number <= e.seq;
    in_ch.in_dram <= e.dram;
    in_ch.globally_allocated <= e.is_global;
    in_ch.byte_size <= e.size;
    in_ch.bytes_per_page <= e.page;
    in_ch.core_count <= e.cores;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_event(e);
    sent++;
  endtask

  // item carrying the next sequence number
  task automatic issue(input event_t e);
    e.seq = issue_seq;
    issue_seq = issue_seq + 1'b1;
    send_event(e);
  endtask

  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    while (board.expected_marks.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_default_cores(input logic [CoreBits-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.default_cores = value;
    cfg_writes++;
  endtask

  initial begin
    logic [CoreBits-1:0] cfg_plan[PHASES];
    int idle_plan[4];
    int stall_plan[4];
    bit order_fault;
    event_t e;

    cfg_plan = '{16'd1, 16'hffff, 16'd0, 16'd0, 16'd3, 16'd0, DefaultCores, 16'd7};
    cfg_plan[3] = CoreBits'($urandom);
    cfg_plan[5] = CoreBits'($urandom_range(2, 1000));
    idle_plan = '{0, 46, 0, 8};
    stall_plan = '{0, 0, 46, 8};
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    sent = 0;
    sat_sent = 0;
    cfg_writes = 0;
    issue_seq = '0;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= '0;
    in_ch.sequence_number <= '0;
    in_ch.in_dram <= 1'b0;
    in_ch.globally_allocated <= 1'b0;
    in_ch.byte_size <= '0;
    in_ch.bytes_per_page <= '0;
    in_ch.core_count <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items, default core count still at its reset value
    issue(ev(OP_CB_ALLOC, 1'b1, 1'b0, SIZE_FULL, '0, '0));
    issue(ev(OP_CB_ALLOC, 1'b0, 1'b1, 31'd12345, 31'd1, 16'd1));
    issue(ev(OP_CB_ALLOC, 1'b0, 1'b0, '0, '0, '0));
    issue(ev(OP_BUF_ALLOC, 1'b0, 1'b0, '0, 31'd1, 16'd1));
    issue(ev(OP_BUF_ALLOC, 1'b0, 1'b0, SIZE_FULL, 31'd1, '0));
    issue(ev(OP_BUF_ALLOC, 1'b0, 1'b1, SIZE_FULL, SIZE_FULL, 16'hffff));
    issue(ev(OP_BUF_ALLOC, 1'b0, 1'b0, 31'd10000, 31'd3, 16'd7));
    issue(ev(OP_BUF_ALLOC, 1'b0, 1'b0, 31'd1000, 31'd4096, 16'd3));
    // dram buffers are skipped even with a zero page size
    issue(ev(OP_BUF_ALLOC, 1'b1, 1'b0, SIZE_FULL, '0, '0));
    issue(ev(OP_BUF_FREE, 1'b1, 1'b1, SIZE_FULL, '0, 16'd1));
    issue(ev(OP_CB_FREE_ALL, 1'b0, 1'b0, '0, '0, '0));
    issue(ev(OP_BUF_FREE, 1'b0, 1'b0, SIZE_FULL, 31'd1, '0));
    issue(ev(OP_CB_ALLOC, 1'b0, 1'b0, 31'd5000, 31'd7, 16'd2));
    // frees beyond what is held must floor at zero
    issue(ev(OP_BUF_FREE, 1'b0, 1'b0, SIZE_FULL, SIZE_FULL, 16'd1));
    issue(ev(OP_BUF_FREE, 1'b0, 1'b0, SIZE_FULL, SIZE_FULL, 16'd1));
    for (int op = OP_OTHER; op <= OP_LAST; op++)
      issue(ev(OpBits'(op), 1'b1, 1'b1, SIZE_FULL, SIZE_FULL, 16'hffff));
    issue(ev(OP_CB_FREE_ALL, 1'b1, 1'b1, SIZE_FULL, SIZE_FULL, 16'hffff));
    issue(ev(OP_CB_ALLOC, 1'b0, 1'b0, 31'd1, '0, '0));

    for (int p = 0; p < PHASES; p++) begin
      drain(4);
      write_default_cores(cfg_plan[p]);
      send_idle_pct = idle_plan[p % 4];
      stall_pct = stall_plan[p % 4];
      if (p == 5) begin
        // receiver held off while the sender keeps offering items
        send_idle_pct = 0;
        hold_req = PRESSURE_HOLD;
        repeat (PRESSURE_ITEMS) issue(random_event());
        send_idle_pct = idle_plan[p % 4];
      end
      repeat (ITEMS_PER_PHASE) issue(random_event());
    end

    // stack maximal circular allocations, then free from there
    drain(4);
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (SAT_ITEMS) begin
      issue(ev(OP_CB_ALLOC, 1'b0, 1'b0, SIZE_FULL, '0, '0));
      sat_sent++;
    end
    issue(ev(OP_BUF_ALLOC, 1'b0, 1'b0, SIZE_FULL, 31'd1, 16'd1));
    issue(ev(OP_BUF_FREE, 1'b0, 1'b0, 31'd4096, 31'd512, 16'd2));
    issue(ev(OP_CB_FREE_ALL, 1'b0, 1'b0, '0, '0, '0));
    issue(ev(OP_CB_ALLOC, 1'b0, 1'b0, 31'd77, '0, '0));
    issue(ev(OP_BUF_ALLOC, 1'b0, 1'b0, 31'd9999, 31'd100, '0));

    // the fault latches until reset, so only one kind is reachable per run
    send_idle_pct = 8;
    stall_pct = 8;
    order_fault = 1'($urandom_range(1));
    if (order_fault) begin
      e = random_event();
      e.seq = issue_seq + SeqBits'($urandom_range(1, 32'hffff_ffff));
      send_event(e);
    end else begin
      issue(ev(OP_BUF_ALLOC, 1'b0, 1'b0, pick_size(), '0, pick_cores()));
    end
    repeat (NOISE_ITEMS) begin
      e = ev(OpBits'($urandom), 1'($urandom), 1'($urandom), SizeBits'($urandom),
             SizeBits'($urandom), CoreBits'($urandom));
      e.seq = $urandom;
      send_event(e);
    end
    e = ev(OP_CB_ALLOC, 1'b0, 1'b0, 31'd100, 31'd1, 16'd1);
    e.seq = issue_seq;
    send_event(e);

    drain(SETTLE_CYCLES);
    if (board.expected_marks.size() != 0) begin
      board.failures += board.expected_marks.size();
      $display("%0d results never arrived", board.expected_marks.size());
    end

    $display("%0d items sent (%0d maximal circular allocations), %0d results checked",
             sent, sat_sent, board.checked);
    $display("%0d default core count settings, closed by a latched %s fault",
             cfg_writes + 1, order_fault ? "sequence" : "page-size");
    if (board.failures == 0)
      $display("per_core_memory_watermark test passed");
    else
      $display("per_core_memory_watermark test failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/pcmw_pkg.sv
sv/pcmw_channels.sv
sv/pcmw_div.sv
sv/pcmw_mul.sv
sv/per_core_memory_watermark.sv
tb/tb.sv
